// File: src/gcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared widths, Q61 constants and elaboration-time helpers for the
// great-circle distance pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int LAT_W    = 28;
  localparam int LON_W    = 29;
  localparam int DLON_W   = 30;
  localparam int ANG_W    = 28;
  localparam int DIST_W   = 24;
  localparam int RADIUS_W = 24;
  localparam int Q_W      = 64;
  localparam int ROOT_W   = 63;
  localparam int REM_W    = 66;
  localparam int SQ_W     = 126;

  localparam logic signed [63:0] ONE_Q      = 64'sh2000_0000_0000_0000;
  localparam logic signed [63:0] THREE_Q    = 64'sh6000_0000_0000_0000;
  localparam logic signed [63:0] HALF_PI    = 64'sh3243_F6A8_885A_308D;
  localparam logic signed [63:0] QUARTER_PI = 64'sh1921_FB54_442D_1847;
  localparam logic [63:0]        PI_Q61     = 64'h6487_ED51_10B4_611A;

  localparam logic signed [31:0] FULL_TURN    = 32'sd377487360;
  localparam logic signed [31:0] HALF_TURN    = 32'sd188743680;
  localparam logic signed [31:0] QUARTER_TURN = 32'sd94371840;

  // radians per input unit, Q61, split for two narrow products
  localparam logic [63:0] RAD_FULL = (PI_Q61 + 64'd94371840) / 64'd188743680;
  localparam logic [17:0] RAD_LO   = RAD_FULL[17:0];
  localparam logic [17:0] RAD_HI   = RAD_FULL[35:18];

  localparam logic [DIST_W-1:0]   DIST_MAX     = '1;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd1632867;

  typedef struct packed {
    logic                    neg;
    logic signed [ANG_W-1:0] r;
  } red_t;

  // restoring long division, elaboration only
  function automatic logic [63:0] f_udiv(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-i) in Q61
  function automatic logic signed [63:0] f_atan(input int i);
    logic signed [63:0] acc;
    logic [63:0]        term;
    int                 odd;
    int                 prod;
    acc = '0;
    if (i == 0) begin
      acc = QUARTER_PI;
    end else begin
      for (int k = 0; k < 62; k++) begin
        odd  = 2 * k + 1;
        prod = i * odd;
        if (prod <= 61) begin
          term = f_udiv(64'd1 << (61 - prod), 64'(odd));
          if ((k & 1) != 0) acc = acc - $signed(term);
          else acc = acc + $signed(term);
        end
      end
    end
    return acc;
  endfunction

  // Q61 product, round half away from zero, saturate
  function automatic logic signed [63:0] f_mulq(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic         neg;
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [127:0] pr;
    logic [66:0]  m;
    logic [63:0]  mm;
    neg = a[63] ^ b[63];
    ma  = a[63] ? 64'(-a) : 64'(a);
    mb  = b[63] ? 64'(-b) : 64'(b);
    pr  = 128'(ma) * 128'(mb);
    pr  = pr + (128'd1 << 60);
    m   = pr[127:61];
    mm  = (|m[66:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : {1'b0, m[62:0]};
    return neg ? -$signed(mm) : $signed(mm);
  endfunction

  // inverse CORDIC gain for n stages
  function automatic logic signed [63:0] f_inv_gain(input int n);
    logic [63:0]        p;
    logic signed [63:0] r;
    logic signed [63:0] t;
    p = 64'(ONE_Q);
    r = $signed((64'd3 << 61) / 64'd5);
    for (int i = 0; i < n; i++) begin
      if (2 * i < 64) p = p + (p >> (2 * i));
    end
    for (int j = 0; j < 6; j++) begin
      t = THREE_Q - f_mulq($signed(p), f_mulq(r, r));
      r = f_mulq(r, t) >>> 1;
    end
    return r;
  endfunction

  // wrap to [-180, 180) and fold into [-90, 90]
  function automatic red_t f_reduce(input logic signed [DLON_W-1:0] d);
    logic signed [31:0] m;
    red_t               res;
    m       = 32'(d);
    res.neg = 1'b0;
    if (m >= FULL_TURN) m = m - FULL_TURN;
    else if (m <= -FULL_TURN) m = m + FULL_TURN;
    if (m >= HALF_TURN) m = m - FULL_TURN;
    if (m < -HALF_TURN) m = m + FULL_TURN;
    if (m > QUARTER_TURN) begin
      m       = m - HALF_TURN;
      res.neg = 1'b1;
    end else if (m < -QUARTER_TURN) begin
      m       = m + HALF_TURN;
      res.neg = 1'b1;
    end
    res.r = ANG_W'(m);
    return res;
  endfunction

endpackage

// File: src/gcd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_if
// Valid/ready channels for point pairs, distances and the radius register.
// ----------------------------------------------------------------------------
interface gcd_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [gcd_pkg::LAT_W-1:0] first_latitude;
  logic signed [gcd_pkg::LON_W-1:0] first_longitude;
  logic signed [gcd_pkg::LAT_W-1:0] second_latitude;
  logic signed [gcd_pkg::LON_W-1:0] second_longitude;
  modport source (output valid, first_latitude, first_longitude, second_latitude,
                  second_longitude, input ready);
  modport sink (input valid, first_latitude, first_longitude, second_latitude,
                second_longitude, output ready);
endinterface

interface gcd_out_if;
  logic                          valid;
  logic                          ready;
  logic [gcd_pkg::DIST_W-1:0] distance;
  modport source (output valid, distance, input ready);
  modport sink (input valid, distance, output ready);
endinterface

interface gcd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gcd_pkg::RADIUS_W-1:0] sphere_radius;
  modport source (output valid, sphere_radius, input ready);
  modport sink (input valid, sphere_radius, output ready);
endinterface

// File: src/gcd_rot_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_rot_cell
// One rotation-mode CORDIC micro-rotation with a fixed shift.
// ----------------------------------------------------------------------------
module gcd_rot_cell import gcd_pkg::*; #(
  parameter int                 SHIFT = 0,
  parameter logic signed [63:0] ATAN  = '0,
  parameter int                 TAG_W = 1
) (
  input  logic                  clk,
  input  logic                  ce,
  input  logic signed [Q_W-1:0] x_in,
  input  logic signed [Q_W-1:0] y_in,
  input  logic signed [Q_W-1:0] z_in,
  input  logic [TAG_W-1:0]      tag_in,
  output logic signed [Q_W-1:0] x_out,
  output logic signed [Q_W-1:0] y_out,
  output logic signed [Q_W-1:0] z_out,
  output logic [TAG_W-1:0]      tag_out
);

  logic signed [Q_W-1:0] xs;
  logic signed [Q_W-1:0] ys;

  assign xs = x_in >>> SHIFT;
  assign ys = y_in >>> SHIFT;

  always_ff @(posedge clk) begin
    if (ce) begin
      if (!z_in[Q_W-1]) begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - ATAN;
      end else begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + ATAN;
      end
      tag_out <= tag_in;
    end
  end

endmodule

// File: src/gcd_vec_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_vec_cell
// One vectoring-mode CORDIC micro-rotation; holds still when y is zero.
// ----------------------------------------------------------------------------
module gcd_vec_cell import gcd_pkg::*; #(
  parameter int                 SHIFT = 0,
  parameter logic signed [63:0] ATAN  = '0
) (
  input  logic                  clk,
  input  logic                  ce,
  input  logic signed [Q_W-1:0] x_in,
  input  logic signed [Q_W-1:0] y_in,
  input  logic signed [Q_W-1:0] z_in,
  output logic signed [Q_W-1:0] x_out,
  output logic signed [Q_W-1:0] y_out,
  output logic signed [Q_W-1:0] z_out
);

  logic signed [Q_W-1:0] xs;
  logic signed [Q_W-1:0] ys;

  assign xs = x_in >>> SHIFT;
  assign ys = y_in >>> SHIFT;

  always_ff @(posedge clk) begin
    if (ce) begin
      if (!y_in[Q_W-1] && (|y_in)) begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + ATAN;
      end else if (y_in[Q_W-1]) begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - ATAN;
      end else begin
        x_out <= x_in;
        y_out <= y_in;
        z_out <= z_in;
      end
    end
  end

endmodule

// File: src/gcd_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_sqrt_cell
// One digit of a restoring integer square root: takes two radicand bits,
// produces one root bit.
// ----------------------------------------------------------------------------
module gcd_sqrt_cell import gcd_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic              clk,
  input  logic              ce,
  input  logic [SQ_W-1:0]   n_in,
  input  logic [REM_W-1:0]  rem_in,
  input  logic [ROOT_W-1:0] root_in,
  input  logic [TAG_W-1:0]  tag_in,
  output logic [SQ_W-1:0]   n_out,
  output logic [REM_W-1:0]  rem_out,
  output logic [ROOT_W-1:0] root_out,
  output logic [TAG_W-1:0]  tag_out
);

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic             ge;

  assign rem_sh = {rem_in, n_in[SQ_W-1 -: 2]};
  assign trial  = (REM_W + 2)'({root_in, 2'b01});
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (ce) begin
      n_out    <= n_in << 2;
      rem_out  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_out <= {root_in[ROOT_W-2:0], ge};
      tag_out  <= tag_in;
    end
  end

endmodule

// File: src/gcd_mul64.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_mul64
// 64x64 unsigned multiplier from four 32x32 partial products, three stages.
// ----------------------------------------------------------------------------
module gcd_mul64 import gcd_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             ce,
  input  logic [63:0]      a,
  input  logic [63:0]      b,
  input  logic [TAG_W-1:0] tag_in,
  output logic [127:0]     prod,
  output logic [TAG_W-1:0] tag_out
);

  logic [63:0]      ll;
  logic [63:0]      lh;
  logic [63:0]      hl;
  logic [63:0]      hh;
  logic [64:0]      mid;
  logic [63:0]      ll2;
  logic [63:0]      hh2;
  logic [TAG_W-1:0] tag1;
  logic [TAG_W-1:0] tag2;

  always_ff @(posedge clk) begin
    if (ce) begin
      ll      <= 64'(a[31:0]) * 64'(b[31:0]);
      lh      <= 64'(a[31:0]) * 64'(b[63:32]);
      hl      <= 64'(a[63:32]) * 64'(b[31:0]);
      hh      <= 64'(a[63:32]) * 64'(b[63:32]);
      tag1    <= tag_in;
      mid     <= 65'(lh) + 65'(hl);
      ll2     <= ll;
      hh2     <= hh;
      tag2    <= tag1;
      prod    <= {hh2, ll2} + (128'(mid) << 32);
      tag_out <= tag2;
    end
  end

endmodule

// File: src/gcd_mulq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_mulq
// Signed Q61 multiplier: magnitude stage, 64x64 product, round and saturate.
// ----------------------------------------------------------------------------
module gcd_mulq import gcd_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic                  clk,
  input  logic                  ce,
  input  logic signed [Q_W-1:0] a,
  input  logic signed [Q_W-1:0] b,
  input  logic [TAG_W-1:0]      tag_in,
  output logic signed [Q_W-1:0] p,
  output logic [TAG_W-1:0]      tag_out
);

  logic               neg1;
  logic [63:0]        ma;
  logic [63:0]        mb;
  logic [TAG_W-1:0]   tag1;
  logic [127:0]       prod;
  logic [TAG_W:0]     tag_m;
  logic [127:0]       rnd;
  logic [63:0]        mag;
  logic signed [63:0] p_next;

  always_ff @(posedge clk) begin
    if (ce) begin
      neg1 <= a[Q_W-1] ^ b[Q_W-1];
      ma   <= a[Q_W-1] ? 64'(-a) : 64'(a);
      mb   <= b[Q_W-1] ? 64'(-b) : 64'(b);
      tag1 <= tag_in;
    end
  end

  gcd_mul64 #(.TAG_W(TAG_W + 1)) u_mul (
    .clk     (clk),
    .ce      (ce),
    .a       (ma),
    .b       (mb),
    .tag_in  ({neg1, tag1}),
    .prod    (prod),
    .tag_out (tag_m)
  );

  // round half away from zero on the magnitude, then restore the sign
  always_comb begin
    rnd    = prod + (128'd1 << 60);
    mag    = (|rnd[127:124]) ? 64'h7FFF_FFFF_FFFF_FFFF : {1'b0, rnd[123:61]};
    p_next = tag_m[TAG_W] ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p       <= p_next;
      tag_out <= tag_m[TAG_W-1:0];
    end
  end

endmodule

// File: src/great_circle_distance_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_distance_top
// Great-circle distance by the spherical law of cosines, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   req  - one transaction per point pair (latitude/longitude, 2^-20 degree).
//   rsp  - one transaction per pair: distance in 2^-8 km, saturated.
//   cfg  - write of the sphere radius (2^-8 km); always ready. Write it only
//          while no pair is in flight.
// Throughput: one pair per cycle whenever the pipeline is not frozen by a stall.
// Pipeline: angle capture and reduction, a CORDIC sine/cosine row of
//   CORDIC_STAGES cells per angle, three Q61 multipliers (five stages each,
//   two in sequence), the 1 - sum^2 product, a 63-cell square-root row, a
//   vectoring CORDIC row of CORDIC_STAGES cells and final scaling.
// Reset: rst clears all pipeline valid bits and the output buffer and loads
//   the default radius (6378.388 km).
// Stall: a two-entry output buffer parts the pipeline from rsp. The pipeline
//   keeps advancing, and req stays ready, while that buffer has room or rsp
//   is being drained; only a full buffer with rsp.ready low freezes it.
// ----------------------------------------------------------------------------
module great_circle_distance_top import gcd_pkg::*; #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic       clk,
  input  logic       rst,
  gcd_cfg_if.sink    cfg,
  gcd_in_if.sink     req,
  gcd_out_if.source  rsp
);

  localparam int N          = CORDIC_STAGES;
  localparam int MUL_LAT    = 3;
  localparam int MQ_LAT     = MUL_LAT + 2;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int LAT        = 4 + N + 1 + 2 * MQ_LAT + 2 + MUL_LAT + SQRT_STEPS + 1 + N + 3;
  localparam logic signed [63:0] KINV = f_inv_gain(CORDIC_STAGES);
  localparam logic [1:0] FIFO_FULL = 2'd2;

  // ---------------- flow control ----------------
  logic                ce;
  logic [LAT-1:0]      vld;
  logic [1:0]          fifo_count;
  logic                push;
  logic                pop;

  assign ce        = (fifo_count != FIFO_FULL) || rsp.ready;
  assign req.ready = ce;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[LAT-2:0], req.valid};
    end
  end

  // ---------------- radius register ----------------
  logic [RADIUS_W-1:0] radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg.valid) begin
      radius <= cfg.sphere_radius;
    end
  end

  // ---------------- angle capture and reduction ----------------
  logic signed [DLON_W-1:0] ang_q [3];
  red_t                     red_q [3];
  logic signed [46:0]       plo_q [3];
  logic signed [46:0]       phi_q [3];
  logic                     neg3  [3];
  logic signed [Q_W-1:0]    z4    [3];
  logic                     neg4  [3];

  always_ff @(posedge clk) begin
    if (ce) begin
      ang_q[0] <= DLON_W'(req.first_latitude);
      ang_q[1] <= DLON_W'(req.second_latitude);
      ang_q[2] <= DLON_W'(req.second_longitude) - DLON_W'(req.first_longitude);
      for (int k = 0; k < 3; k++) begin
        red_q[k] <= f_reduce(ang_q[k]);
        // degrees to radians as two narrow partial products
        plo_q[k] <= 47'(red_q[k].r) * 47'($signed({1'b0, RAD_LO}));
        phi_q[k] <= 47'(red_q[k].r) * 47'($signed({1'b0, RAD_HI}));
        neg3[k]  <= red_q[k].neg;
        z4[k]    <= (64'(phi_q[k]) <<< 18) + 64'(plo_q[k]);
        neg4[k]  <= neg3[k];
      end
    end
  end

  // ---------------- sine/cosine rows ----------------
  logic signed [Q_W-1:0] rx   [3][N+1];
  logic signed [Q_W-1:0] ry   [3][N+1];
  logic signed [Q_W-1:0] rz   [3][N+1];
  logic                  rneg [3][N+1];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    assign rx[k][0]   = KINV;
    assign ry[k][0]   = '0;
    assign rz[k][0]   = z4[k];
    assign rneg[k][0] = neg4[k];
    for (genvar i = 0; i < N; i++) begin : g_cell
      gcd_rot_cell #(.SHIFT(i), .ATAN(f_atan(i)), .TAG_W(1)) u_cell (
        .clk     (clk),
        .ce      (ce),
        .x_in    (rx[k][i]),
        .y_in    (ry[k][i]),
        .z_in    (rz[k][i]),
        .tag_in  (rneg[k][i]),
        .x_out   (rx[k][i+1]),
        .y_out   (ry[k][i+1]),
        .z_out   (rz[k][i+1]),
        .tag_out (rneg[k][i+1])
      );
    end
  end

  // undo the quadrant fold
  logic signed [Q_W-1:0] s1_q, c1_q, s2_q, c2_q, cd_q;

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_q <= rneg[0][N] ? -ry[0][N] : ry[0][N];
      c1_q <= rneg[0][N] ? -rx[0][N] : rx[0][N];
      s2_q <= rneg[1][N] ? -ry[1][N] : ry[1][N];
      c2_q <= rneg[1][N] ? -rx[1][N] : rx[1][N];
      cd_q <= rneg[2][N] ? -rx[2][N] : rx[2][N];
    end
  end

  // ---------------- cosine sum ----------------
  logic signed [Q_W-1:0] ss_p;
  logic signed [Q_W-1:0] cc_p;
  logic signed [Q_W-1:0] cd_d;
  logic signed [Q_W-1:0] ccd_p;
  logic signed [Q_W-1:0] ss_d;

  gcd_mulq #(.TAG_W(1)) u_mq_ss (
    .clk (clk), .ce (ce), .a (s1_q), .b (s2_q), .tag_in (1'b0),
    .p (ss_p), .tag_out ()
  );

  gcd_mulq #(.TAG_W(Q_W)) u_mq_cc (
    .clk (clk), .ce (ce), .a (c1_q), .b (c2_q), .tag_in (cd_q),
    .p (cc_p), .tag_out (cd_d)
  );

  gcd_mulq #(.TAG_W(Q_W)) u_mq_ccd (
    .clk (clk), .ce (ce), .a (cc_p), .b (cd_d), .tag_in (ss_p),
    .p (ccd_p), .tag_out (ss_d)
  );

  logic signed [Q_W:0]   sum_w;
  logic signed [Q_W-1:0] sum_q;
  logic [63:0]           om_q;
  logic [63:0]           op_q;
  logic signed [Q_W-1:0] x_q;

  assign sum_w = 65'(ss_d) + 65'(ccd_p);

  always_ff @(posedge clk) begin
    if (ce) begin
      // clamp to [-1, 1]
      if (sum_w > 65'(ONE_Q)) sum_q <= ONE_Q;
      else if (sum_w < -65'(ONE_Q)) sum_q <= -ONE_Q;
      else sum_q <= Q_W'(sum_w);
      om_q <= 64'(ONE_Q - sum_q);
      op_q <= 64'(ONE_Q + sum_q);
      x_q  <= sum_q;
    end
  end

  // ---------------- sqrt(1 - sum^2) ----------------
  logic [127:0]          rad_p;
  logic signed [Q_W-1:0] x_m;

  gcd_mul64 #(.TAG_W(Q_W)) u_mul_rad (
    .clk (clk), .ce (ce), .a (om_q), .b (op_q), .tag_in (x_q),
    .prod (rad_p), .tag_out (x_m)
  );

  logic [SQ_W-1:0]   sn    [SQRT_STEPS+1];
  logic [REM_W-1:0]  srem  [SQRT_STEPS+1];
  logic [ROOT_W-1:0] sroot [SQRT_STEPS+1];
  logic [Q_W-1:0]    sx    [SQRT_STEPS+1];

  assign sn[0]    = rad_p[SQ_W-1:0];
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign sx[0]    = x_m;

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    gcd_sqrt_cell #(.TAG_W(Q_W)) u_cell (
      .clk      (clk),
      .ce       (ce),
      .n_in     (sn[j]),
      .rem_in   (srem[j]),
      .root_in  (sroot[j]),
      .tag_in   (sx[j]),
      .n_out    (sn[j+1]),
      .rem_out  (srem[j+1]),
      .root_out (sroot[j+1]),
      .tag_out  (sx[j+1])
    );
  end

  // ---------------- arccosine by vectoring ----------------
  logic signed [Q_W-1:0] vx [N+1];
  logic signed [Q_W-1:0] vy [N+1];
  logic signed [Q_W-1:0] vz [N+1];
  logic signed [Q_W-1:0] xs_in;
  logic signed [Q_W-1:0] ys_in;

  assign xs_in = $signed(sx[SQRT_STEPS]);
  assign ys_in = $signed({1'b0, sroot[SQRT_STEPS]});

  // negative x: pre-rotate by 90 degrees
  always_ff @(posedge clk) begin
    if (ce) begin
      if (xs_in[Q_W-1]) begin
        vx[0] <= ys_in;
        vy[0] <= -xs_in;
        vz[0] <= HALF_PI;
      end else begin
        vx[0] <= xs_in;
        vy[0] <= ys_in;
        vz[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    gcd_vec_cell #(.SHIFT(i), .ATAN(f_atan(i))) u_cell (
      .clk   (clk),
      .ce    (ce),
      .x_in  (vx[i]),
      .y_in  (vy[i]),
      .z_in  (vz[i]),
      .x_out (vx[i+1]),
      .y_out (vy[i+1]),
      .z_out (vz[i+1])
    );
  end

  // ---------------- scale by radius, round, saturate ----------------
  logic [62:0]        zc;
  logic [55:0]        dlo_q;
  logic [54:0]        dhi_q;
  logic [87:0]        dsum_q;
  logic [88:0]        drnd;
  logic [DIST_W-1:0]  dist_q;

  assign zc   = vz[N][Q_W-1] ? '0 : vz[N][62:0];
  assign drnd = 89'(dsum_q) + (89'd1 << 60);

  always_ff @(posedge clk) begin
    if (ce) begin
      dlo_q  <= 56'(zc[31:0]) * 56'(radius);
      dhi_q  <= 55'(zc[62:32]) * 55'(radius);
      dsum_q <= (88'(dhi_q) << 32) + 88'(dlo_q);
      dist_q <= (|drnd[88:61+DIST_W]) ? DIST_MAX : drnd[61 +: DIST_W];
    end
  end

  // ---------------- output buffer ----------------
  logic [DIST_W-1:0] fifo_mem [2];
  logic              wr_ptr;
  logic              rd_ptr;

  assign push         = ce && vld[LAT-1];
  assign pop          = rsp.valid && rsp.ready;
  assign rsp.valid    = (fifo_count != 2'd0);
  assign rsp.distance = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_count <= '0;
      wr_ptr     <= 1'b0;
      rd_ptr     <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fifo_count <= fifo_count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= dist_q;
    end
  end

endmodule

// File: src/gcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_checker
// Port-level checks on the distance pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module gcd_checker import gcd_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [DIST_W-1:0] rsp_distance,
  input logic              cfg_ready
);

  // a waiting result stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance))
    else $error("rsp dropped or changed while stalled");

  // reset empties the output buffer
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("rsp valid right after reset");

  // input only backs up when the output side is full and stalled
  a_req_ready: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid || rsp_ready |-> req_ready)
    else $error("req stalled while rsp side has room");

  // radius register never pushes back
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    req_valid || !req_valid |-> cfg_ready)
    else $error("cfg not ready");

endmodule

bind great_circle_distance_top gcd_checker u_gcd_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_distance (rsp.distance),
  .cfg_ready    (cfg.ready)
);

// File: sim/tb_great_circle_distance_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_great_circle_distance_top
// Self-checking bench for the great-circle distance pipeline. A Q61 model of
// the same arithmetic predicts each distance. Results are compared in order
// under random source gaps and sink stalls, across several radius settings.
// ----------------------------------------------------------------------------
module tb_great_circle_distance_top;
  import gcd_pkg::*;

  localparam int      STAGES      = 24;
  localparam int      PIPE_DEPTH  = 2 * STAGES + 87;
  localparam int      DRAIN_WAIT  = PIPE_DEPTH + 20;
  localparam int      CYCLE_LIMIT = 400000;
  localparam longint  Q_ONE       = 64'sh2000_0000_0000_0000;
  localparam longint  Q_HALF_PI   = 64'sh3243_F6A8_885A_308D;
  localparam longint  Q_QTR_PI    = 64'sh1921_FB54_442D_1847;
  localparam longint  TURN        = 377487360;
  localparam longint  HALF        = 188743680;
  localparam longint  QTR         = 94371840;
  localparam logic [63:0] PI_BITS = 64'h6487_ED51_10B4_611A;

  logic clk;
  logic rst;

  gcd_cfg_if cfg_ch ();
  gcd_in_if  req_ch ();
  gcd_out_if rsp_ch ();

  great_circle_distance_top #(.CORDIC_STAGES(STAGES)) dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Free-running clock, 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Distance predictor: Q61 fixed point, CORDIC sin/cos and arccosine.
  // ---------------------------------------------------------------------------
  longint        atan_q [STAGES];
  longint        gain_inv;
  longint        rad_per_unit;
  logic [23:0]   radius_now;
  logic [23:0]   dist_expected [$];

  // Product in Q61, rounded half away from zero, saturated.
  function automatic longint q_mul(longint a, longint b);
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [127:0] p;
    logic [127:0] m;
    bit           neg;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    p   = {64'd0, ma} * {64'd0, mb};
    p   = p + (128'd1 << 60);
    m   = p >> 61;
    if (m > 128'h7FFF_FFFF_FFFF_FFFF) m = 128'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint arctan_step(int i);
    longint      acc;
    logic [63:0] term;
    int          odd;
    if (i == 0) return Q_QTR_PI;
    acc = 0;
    for (int k = 0; i * (2 * k + 1) <= 61; k++) begin
      odd  = 2 * k + 1;
      term = (64'd1 << (61 - i * odd)) / 64'(odd);
      if (k & 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    return acc;
  endfunction

  // 1/sqrt(prod(1 + 4^-i)) by Newton iteration from 0.6.
  function automatic longint cordic_gain_inv();
    logic [63:0] p;
    longint      r;
    longint      t;
    p = Q_ONE;
    r = (Q_ONE * 3) / 5;
    for (int i = 0; i < STAGES; i++) p = p + (p >> (2 * i));
    for (int n = 0; n < 6; n++) begin
      t = 3 * Q_ONE - q_mul(longint'(p), q_mul(r, r));
      r = q_mul(r, t) >>> 1;
    end
    return r;
  endfunction

  // Wrap to one turn, fold into +-90 degrees, rotate.
  function automatic void sin_cos_units(longint d, output longint sn, output longint cs);
    longint r;
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    bit     flip;
    r    = d % TURN;
    flip = 1'b0;
    if (r >= HALF) r -= TURN;
    if (r < -HALF) r += TURN;
    if (r > QTR) begin
      r -= HALF;
      flip = 1'b1;
    end else if (r < -QTR) begin
      r += HALF;
      flip = 1'b1;
    end
    z = r * rad_per_unit;
    x = gain_inv;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_q[i];
      end else begin
        x += ys; y -= xs; z += atan_q[i];
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  function automatic logic [62:0] floor_sqrt(logic [127:0] v);
    logic [63:0] r;
    logic [63:0] c;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= v) r = c;
    end
    return r[62:0];
  endfunction

  function automatic logic [23:0] predict_distance(longint lat1, longint lon1,
                                                   longint lat2, longint lon2);
    longint       s1, c1, s2, c2, sd, cd;
    longint       cos_angle;
    longint       x, y, z, xs, ys, t;
    logic [127:0] p;
    sin_cos_units(lat1, s1, c1);
    sin_cos_units(lat2, s2, c2);
    sin_cos_units(lon2 - lon1, sd, cd);
    cos_angle = q_mul(s1, s2) + q_mul(q_mul(c1, c2), cd);
    if (cos_angle > Q_ONE) cos_angle = Q_ONE;
    if (cos_angle < -Q_ONE) cos_angle = -Q_ONE;
    p = {64'd0, 64'(Q_ONE - cos_angle)} * {64'd0, 64'(Q_ONE + cos_angle)};
    x = cos_angle;
    y = longint'({1'b0, floor_sqrt(p)});
    z = 0;
    if (x < 0) begin
      t = x; x = y; y = -t; z = Q_HALF_PI;
    end
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += atan_q[i];
      end else if (y < 0) begin
        x -= ys; y += xs; z -= atan_q[i];
      end
    end
    if (z < 0) z = 0;
    p = {64'd0, 64'(z)} * {104'd0, radius_now};
    p = (p + (128'd1 << 60)) >> 61;
    return (p > 128'hFF_FFFF) ? 24'hFF_FFFF : p[23:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Flow control and bookkeeping
  // ---------------------------------------------------------------------------
  bit     no_idle;
  int     n_pairs;
  int     n_checked;
  int     n_mismatch;
  int     cycles;

  // Sink side: stall about a quarter of the cycles unless idling is off.
  always @(posedge clk) begin
    if (rst) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= no_idle || ($urandom_range(99) >= 26);
  end

  // Check each distance transaction against the oldest prediction. Sample at
  // the falling edge, where valid and ready already hold the values that the
  // next rising edge sees.
  always @(negedge clk) begin
    logic [23:0] want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      n_checked++;
      if (dist_expected.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("[%0t] distance %0d with nothing expected", $realtime, rsp_ch.distance);
      end else begin
        want = dist_expected.pop_front();
        if (rsp_ch.distance !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("[%0t] distance mismatch: expected %0d, got %0d",
                     $realtime, want, rsp_ch.distance);
        end
      end
    end
  end

  // Watchdog: abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d distances outstanding",
               cycles, dist_expected.size());
      $display("tb_great_circle_distance_top: FAIL");
      $finish;
    end
  end

  // Send one point pair; predict its distance when the transaction happens.
  // Entered and left right after a rising edge.
  task automatic send_pair(input logic [27:0] lat1, input logic [28:0] lon1,
                           input logic [27:0] lat2, input logic [28:0] lon2);
    bit taken;
    while (!no_idle && $urandom_range(99) < 26) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid            <= 1'b1;
    req_ch.first_latitude   <= lat1;
    req_ch.first_longitude  <= lon1;
    req_ch.second_latitude  <= lat2;
    req_ch.second_longitude <= lon2;
    do begin
      @(negedge clk);
      taken = req_ch.ready;
      @(posedge clk);
    end while (!taken);
    dist_expected.push_back(predict_distance(longint'($signed(lat1)), longint'($signed(lon1)),
                                             longint'($signed(lat2)), longint'($signed(lon2))));
    n_pairs++;
  endtask

  // Drop valid, let every distance come back and the pipeline empty.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (dist_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Write the radius register while the pipeline is empty.
  task automatic write_radius(input logic [23:0] value);
    bit taken;
    drain();
    cfg_ch.valid         <= 1'b1;
    cfg_ch.sphere_radius <= value;
    do begin
      @(negedge clk);
      taken = cfg_ch.ready;
      @(posedge clk);
    end while (!taken);
    cfg_ch.valid <= 1'b0;
    radius_now = value;
  endtask

  function automatic logic [27:0] rand_lat();
    return 28'($signed($urandom_range(2 * QTR)) - QTR);
  endfunction

  function automatic logic [28:0] rand_lon();
    return 29'($signed($urandom_range(2 * HALF)) - HALF);
  endfunction

  // Mostly in-range angles, some with every bit of the field random.
  task automatic send_random_pair();
    if ($urandom_range(9) == 0)
      send_pair(28'($urandom), 29'($urandom), 28'($urandom), 29'($urandom));
    else
      send_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Poles, date line, identical and antipodal points, out-of-range angles.
  task automatic test_directed();
    logic [27:0] lmax;
    logic [28:0] gmax;
    lmax = 28'(QTR);
    gmax = 29'(HALF);
    send_pair('0, '0, '0, '0);
    send_pair(lmax, '0, -lmax, '0);
    send_pair(lmax, gmax, lmax, -gmax);
    send_pair('0, '0, '0, gmax);
    send_pair('0, -gmax, '0, gmax);
    send_pair('0, 29'(QTR), '0, -29'(QTR));
    send_pair(-lmax, '0, -lmax, 29'(12345));
    send_pair(28'(12345), 29'(-777), 28'(12345), 29'(-777));
    send_pair(28'(12345), 29'(-777), -28'(12345), 29'(HALF - 777));
    send_pair(28'h7FF_FFFF, 29'h0FFF_FFFF, 28'h800_0000, 29'h1000_0000);
    send_pair(28'h800_0000, 29'h1000_0000, 28'h7FF_FFFF, 29'h0FFF_FFFF);
    send_pair(28'(QTR + 1), '0, '0, '0);
    send_pair(28'(-QTR - 1), '0, 28'(QTR + 5000), 29'(HALF + 1));
    send_pair('0, 29'(1), '0, '0);
    send_pair(28'(1), '0, '0, '0);
    send_pair('0, 29'h0FFF_FFFF, '0, 29'h1000_0000);
    send_pair(lmax - 28'd1, '0, lmax, 29'(HALF - 1));
    send_pair(28'(43000000), 29'(9000000), 28'(-43000000), 29'(-179743680));
  endtask

  // Radius extremes: zero gives zero, the maximum saturates long arcs.
  task automatic test_radius_extremes();
    write_radius('0);
    repeat (40) send_random_pair();
    send_pair(28'(QTR), '0, -28'(QTR), '0);
    write_radius('1);
    repeat (40) send_random_pair();
    send_pair(28'(QTR), '0, -28'(QTR), '0);
    send_pair('0, '0, '0, 29'(1));
    write_radius(24'h80_0000);
    repeat (20) send_random_pair();
  endtask

  // Random pairs across several radii, with a stretch of full-rate traffic.
  task automatic test_random(input int count);
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 0) write_radius(RADIUS_RESET);
      else write_radius(24'($urandom));
      no_idle = (ph == 2);
      for (int n = 0; n < count / 4; n++) send_random_pair();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < STAGES; i++) atan_q[i] = arctan_step(i);
    gain_inv     = cordic_gain_inv();
    rad_per_unit = longint'((PI_BITS + 64'd94371840) / 64'd188743680);
    radius_now   = RADIUS_RESET;
    no_idle      = 1'b0;
    n_pairs      = 0;
    n_checked    = 0;
    n_mismatch   = 0;
    cycles       = 0;

    rst                     <= 1'b1;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.sphere_radius    <= '0;
    req_ch.valid            <= 1'b0;
    req_ch.first_latitude   <= '0;
    req_ch.first_longitude  <= '0;
    req_ch.second_latitude  <= '0;
    req_ch.second_longitude <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default radius first, then the register walk
    test_directed();
    test_radius_extremes();
    test_random(1280);
    drain();

    $display("covered %0d point pairs, %0d distances checked, radius 0 to full scale",
             n_pairs, n_checked);
    $display("%0d mismatches", n_mismatch);
    if (n_mismatch == 0) begin
      $display("tb_great_circle_distance_top: PASS");
    end else begin
      $display("tb_great_circle_distance_top: FAIL");
    end
    $finish;
  end

endmodule

// File: great_circle_distance_top.f
src/gcd_pkg.sv
src/gcd_if.sv
src/gcd_rot_cell.sv
src/gcd_vec_cell.sv
src/gcd_sqrt_cell.sv
src/gcd_mul64.sv
src/gcd_mulq.sv
src/great_circle_distance_top.sv
src/gcd_checker.sv
sim/tb_great_circle_distance_top.sv
